FILE: sv/fss_pkg.sv
package fss_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int ADDR_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int CHAR_W      = 8;
  localparam int SCORE_W     = 17;
  localparam int SUM_W       = SCORE_W + 1;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

  localparam logic signed [SUM_W-1:0] SCORE_MAX  = 18'sd65535;
  localparam logic signed [SUM_W-1:0] SCORE_MIN  = -18'sd65536;
  localparam logic signed [SUM_W-1:0] MISS_DELTA = -18'sd10;
  localparam logic signed [SUM_W-1:0] TAIL_DELTA = -18'sd1;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_SUBJECT = 2'd2,
    FUNC_FINISH  = 2'd3
  } func_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: sv/fss_ram.sv
module fss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fuzzy_subsequence_scorer_unit.sv
// Fuzzy subsequence scorer.
// The slave channel carries commands: s_tuser selects the function (clear
// pattern, append pattern byte, subject byte, finish) and s_tdata carries the
// byte. Only a finish produces a transaction on the master channel, holding
// the score in m_tdata and the matched and overflow flags in m_tuser.
// A transaction can be accepted on every clock unless a pending result
// holds s_tready low. The pattern lives in a single-port-write RAM whose
// registered read is always aimed at the next match position; a write to
// that same entry is forwarded, so subject bytes need no stall.
// A finish result appears on the master channel in the cycle after the finish
// is accepted. The result register is the only buffer: while it is full and
// the receiver holds m_tready low, s_tready is low as well.
// Reset empties the pattern, clears the overflow flag and the scoring state
// and drops any pending result; the pattern RAM itself is not cleared, as
// only entries below the pattern length are ever read.
module fuzzy_subsequence_scorer_unit
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [16:0] score, [23:17] zero
  output logic [1:0]  m_tuser    // [0] matched, [1] pattern_overflow
);

  logic [CNT_W-1:0]         plen, plen_next;
  logic [CNT_W-1:0]         mpos, mpos_next;
  logic [CNT_W-1:0]         run, run_next;
  logic signed [SCORE_W-1:0] score, score_next;
  logic                     ovf, ovf_next;

  logic                     accept;
  func_t                    func;
  logic [CHAR_W-1:0]        c;
  logic                     we;
  logic [ADDR_W-1:0]        raddr;
  logic [CHAR_W-1:0]        ram_q;
  logic [CHAR_W-1:0]        p;
  logic                     fwd_hit;
  logic [CHAR_W-1:0]        fwd_data;
  logic signed [SUM_W-1:0]  delta;
  logic signed [SUM_W-1:0]  sum;
  logic                     upd;
  logic [SUM_W-1:0]         run_ext;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign func     = func_t'(s_tuser);
  assign c        = s_tdata;
  assign p        = fwd_hit ? fwd_data : ram_q;
  assign run_ext  = {{(SUM_W-CNT_W){1'b0}}, run};
  assign raddr    = mpos_next[ADDR_W-1:0];

  always_comb begin
    plen_next  = plen;
    mpos_next  = mpos;
    run_next   = run;
    score_next = score;
    ovf_next   = ovf;
    we         = 1'b0;
    upd        = 1'b0;
    delta      = '0;
    if (accept) begin
      case (func)
        FUNC_CLEAR: begin
          plen_next  = '0;
          ovf_next   = 1'b0;
          mpos_next  = '0;
          run_next   = '0;
          score_next = '0;
        end
        FUNC_APPEND: begin
          if (c != SPACE_CODE) begin
            if (plen >= CNT_W'(PATTERN_MAX)) begin
              ovf_next = 1'b1;
            end else begin
              we        = 1'b1;
              plen_next = plen + 1'b1;
            end
          end
        end
        FUNC_SUBJECT: begin
          if (mpos < plen) begin
            if (c != SPACE_CODE) begin
              upd = 1'b1;
              if (fold_case(c) == fold_case(p)) begin
                delta     = $signed((run_ext << 3) + (run_ext << 1))
                            - ((c != p) ? SUM_W'(1) : SUM_W'(0));
                run_next  = run + 1'b1;
                mpos_next = mpos + 1'b1;
              end else begin
                delta    = MISS_DELTA;
                run_next = '0;
              end
            end
          end else begin
            upd   = 1'b1;
            delta = TAIL_DELTA;
          end
        end
        FUNC_FINISH: begin
          mpos_next  = '0;
          run_next   = '0;
          score_next = '0;
        end
        default: begin
        end
      endcase
    end
    sum = SUM_W'(score) + delta;
    if (upd) begin
      if (sum > SCORE_MAX) begin
        score_next = SCORE_MAX[SCORE_W-1:0];
      end else if (sum < SCORE_MIN) begin
        score_next = SCORE_MIN[SCORE_W-1:0];
      end else begin
        score_next = sum[SCORE_W-1:0];
      end
    end
  end

  fss_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (PATTERN_MAX)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (we),
    .waddr (plen[ADDR_W-1:0]),
    .wdata (c),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    fwd_hit  <= we && (plen[ADDR_W-1:0] == raddr);
    fwd_data <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen  <= '0;
      mpos  <= '0;
      run   <= '0;
      score <= '0;
      ovf   <= 1'b0;
    end else begin
      plen  <= plen_next;
      mpos  <= mpos_next;
      run   <= run_next;
      score <= score_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && func == FUNC_FINISH) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func == FUNC_FINISH) begin
      m_tuser[0] <= (mpos >= plen);
      m_tuser[1] <= ovf;
      m_tdata    <= {7'd0, (mpos >= plen) ? score : SCORE_W'(0)};
    end
  end

  a_mpos_le_plen: assert property (@(posedge clk) disable iff (rst) mpos <= plen)
    else $error("match position ran past the pattern length");

  a_plen_le_max: assert property (@(posedge clk) disable iff (rst)
    plen <= CNT_W'(PATTERN_MAX))
    else $error("pattern length exceeds the store capacity");

  a_run_le_mpos: assert property (@(posedge clk) disable iff (rst) run <= mpos)
    else $error("run length exceeds the match position");

  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_FINISH |=> m_tvalid)
    else $error("finish transaction produced no result");

endmodule
